// ===== src/u8dec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types and constants of the UTF-8 decoder: lead byte classes, the
// word descriptor passed from front end to back end, and queue sizing.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [20:0] SUPP_BASE  = 21'h010000;
    localparam logic [20:0] BMP_MAX    = 21'h00FFFF;
    localparam logic [20:0] HI_SURR    = 21'h00D800;
    localparam logic [20:0] LO_SURR    = 21'h00DC00;

    localparam logic [0:0] MODE_UTF32 = 1'b0;
    localparam logic [0:0] MODE_UTF16 = 1'b1;

    // lead class: number of continuation bytes, or bad lead
    typedef enum logic [2:0] {
        CLS_SINGLE = 3'd0,
        CLS_TWO    = 3'd1,
        CLS_THREE  = 3'd2,
        CLS_FOUR   = 3'd3,
        CLS_BAD    = 3'd4
    } lead_cls_t;

    // one decoded input word as seen by the back end
    typedef struct packed {
        logic [20:0] cp_a;   // first code point
        logic        has_a;
        logic [6:0]  cp_b;   // second code point (ASCII from tail decode)
        logic        has_b;
        logic        last;   // word carries the end of the string
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic lead_cls_t lead_class(input logic [7:0] b);
        lead_cls_t c;
        if (b <= 8'h7F)
            c = CLS_SINGLE;
        else if (b <= 8'hDF)
            c = CLS_TWO;
        else if (b <= 8'hEF)
            c = CLS_THREE;
        else if (b <= 8'hF7)
            c = CLS_FOUR;
        else
            c = CLS_BAD;
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== src/utf8_to_utf16_or_utf32_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_or_utf32_decoder_core
// UTF-8 byte stream decoder with UTF-32 or UTF-16 output words.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------
//   input    | in_valid / in_stall  | in_byte, in_last
//   output   | out_valid / out_stall| code_unit, unit_valid, end_mark
//   config   | cfg_wr_en            | cfg_wr_data (out_mode)
//
// One input byte per cycle while in_stall is low; a byte that yields two
// words (surrogate pair or two tail characters) holds the back end for both
// words, absorbed by the four-entry descriptor queue. Reset clears the
// sequence count, stop flag, queue pointers and output valid and phase flags.
// in_stall rises only when the queue is full; out_stall backs up the queue.
// ----------------------------------------------------------------------------
module utf8_to_utf16_or_utf32_decoder_core
    import u8dec_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [20:0]      code_unit,
    output logic             unit_valid,
    output logic             end_mark
);

    logic    out_mode_reg, out_mode_next;
    logic    q_push;
    logic    q_pop;
    desc_t   q_wr_data;
    desc_t   q_rd_data;
    q_stat_t q_stat;

    assign out_mode_next = cfg_wr_en ? cfg_wr_data : out_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_mode_reg <= MODE_UTF32;
        else
            out_mode_reg <= out_mode_next;
    end

    u8dec_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_data   (q_wr_data)
    );

    u8dec_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    u8dec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .out_mode   (out_mode_reg),
        .q_data     (q_rd_data),
        .q_stat     (q_stat),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_unit  (code_unit),
        .unit_valid (unit_valid),
        .end_mark   (end_mark)
    );

endmodule
`default_nettype wire

// ===== src/u8dec_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8dec_front
// Accepts UTF-8 bytes, tracks the open sequence and the stop flag, and
// pushes one descriptor per byte that yields code points or ends the string.
// ----------------------------------------------------------------------------
module u8dec_front
    import u8dec_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    input  wire q_stat_t     q_stat,
    output logic             q_push,
    output desc_t            q_data
);

    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;
    logic [7:0] held2_reg, held2_next;
    logic [1:0] count_reg, count_next;
    logic       stopped_reg, stopped_next;

    logic       accept;
    lead_cls_t  cls_b;
    lead_cls_t  cls_h0;
    logic [1:0] need;
    desc_t      d;

    function automatic logic [20:0] asm2(input logic [7:0] s0, input logic [7:0] s1);
        return {10'd0, s0[4:0], s1[5:0]};
    endfunction

    function automatic logic [20:0] asm3(input logic [7:0] s0, input logic [7:0] s1,
                                         input logic [7:0] s2);
        return {5'd0, s0[3:0], s1[5:0], s2[5:0]};
    endfunction

    function automatic logic [20:0] asm4(input logic [7:0] s0, input logic [7:0] s1,
                                         input logic [7:0] s2, input logic [7:0] s3);
        return {s0[2:0], s1[5:0], s2[5:0], s3[5:0]};
    endfunction

    function automatic logic is_ascii_nz(input logic [7:0] b);
        return (b[7] == 1'b0) && (b != 8'h00);
    endfunction

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;
    assign cls_b    = lead_class(in_byte);
    assign cls_h0   = lead_class(held0_reg);
    assign need     = cls_h0[1:0];

    always_comb
    begin
        held0_next   = held0_reg;
        held1_next   = held1_reg;
        held2_next   = held2_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        d            = '0;

        if (accept)
        begin
            if (!stopped_reg)
            begin
                if (count_reg == 2'd0)
                begin
                    if (in_byte == 8'h00)
                        stopped_next = 1'b1;
                    else if (cls_b == CLS_SINGLE)
                    begin
                        d.has_a = 1'b1;
                        d.cp_a  = {13'd0, in_byte};
                    end
                    else if (cls_b != CLS_BAD)
                    begin
                        held0_next = in_byte;
                        count_next = 2'd1;
                    end
                end
                else if (count_reg == need)
                begin
                    // sequence complete with this byte
                    d.has_a    = 1'b1;
                    count_next = 2'd0;
                    case (need)
                        2'd1:    d.cp_a = asm2(held0_reg, in_byte);
                        2'd2:    d.cp_a = asm3(held0_reg, held1_reg, in_byte);
                        default: d.cp_a = asm4(held0_reg, held1_reg, held2_reg, in_byte);
                    endcase
                end
                else
                begin
                    if (count_reg == 2'd1)
                        held1_next = in_byte;
                    else
                        held2_next = in_byte;
                    count_next = count_reg + 2'd1;
                end
            end

            if (in_last)
            begin
                d.last = 1'b1;
                // string cut inside a sequence: drop the lead, decode the tail
                if (!stopped_next && count_next == 2'd2)
                begin
                    if (is_ascii_nz(held1_next))
                    begin
                        d.has_a = 1'b1;
                        d.cp_a  = {13'd0, held1_next};
                    end
                end
                else if (!stopped_next && count_next == 2'd3 && held1_next != 8'h00)
                begin
                    if (held1_next[7] == 1'b0)
                    begin
                        d.has_a = 1'b1;
                        d.cp_a  = {13'd0, held1_next};
                        if (is_ascii_nz(held2_next))
                        begin
                            d.has_b = 1'b1;
                            d.cp_b  = held2_next[6:0];
                        end
                    end
                    else if (lead_class(held1_next) == CLS_TWO)
                    begin
                        d.has_a = 1'b1;
                        d.cp_a  = asm2(held1_next, held2_next);
                    end
                    else if (is_ascii_nz(held2_next))
                    begin
                        d.has_a = 1'b1;
                        d.cp_a  = {13'd0, held2_next};
                    end
                end
                count_next   = 2'd0;
                stopped_next = 1'b0;
            end
        end
    end

    assign q_push = accept && (d.has_a || d.has_b || d.last);
    assign q_data = d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 2'd0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held0_reg <= held0_next;
        held1_reg <= held1_next;
        held2_reg <= held2_next;
    end

endmodule
`default_nettype wire

// ===== src/u8dec_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8dec_queue
// Short descriptor queue between front end and back end.
// ----------------------------------------------------------------------------
module u8dec_queue
    import u8dec_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire desc_t wr_data,
    input  wire logic  pop,
    output desc_t      rd_data,
    output q_stat_t    stat
);

    desc_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_data    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

// ===== src/u8dec_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8dec_back
// Expands queued descriptors into output words: UTF-32 code points or
// UTF-16 units with surrogate pairs, plus bare end markers.
// ----------------------------------------------------------------------------
module u8dec_back
    import u8dec_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        out_mode,
    input  wire desc_t       q_data,
    input  wire q_stat_t     q_stat,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [20:0]      code_unit,
    output logic             unit_valid,
    output logic             end_mark
);

    logic        valid_reg, valid_next;
    logic        phase_reg, phase_next;
    logic [20:0] unit_reg, unit_next;
    logic        uvalid_reg, uvalid_next;
    logic        end_reg, end_next;

    logic        load;
    logic        pair;
    logic        two_words;
    logic [20:0] offs;
    logic [20:0] hi_unit;
    logic [20:0] lo_unit;

    assign pair      = (out_mode == MODE_UTF16) && q_data.has_a && (q_data.cp_a > BMP_MAX);
    assign two_words = pair || (q_data.has_a && q_data.has_b);
    assign offs      = q_data.cp_a - SUPP_BASE;
    assign hi_unit   = HI_SURR + {10'd0, offs[20:10]};
    assign lo_unit   = LO_SURR | {11'd0, offs[9:0]};

    assign load  = !q_stat.empty && (!valid_reg || !out_stall);
    assign q_pop = load && !(two_words && !phase_reg);

    always_comb
    begin
        valid_next  = valid_reg;
        phase_next  = phase_reg;
        unit_next   = unit_reg;
        uvalid_next = uvalid_reg;
        end_next    = end_reg;

        if (load)
        begin
            valid_next = 1'b1;
            if (!phase_reg)
            begin
                // first word of this descriptor
                phase_next  = two_words;
                uvalid_next = q_data.has_a;
                end_next    = q_data.last && !two_words;
                if (!q_data.has_a)
                    unit_next = '0;
                else if (pair)
                    unit_next = hi_unit;
                else
                    unit_next = q_data.cp_a;
            end
            else
            begin
                phase_next  = 1'b0;
                uvalid_next = 1'b1;
                end_next    = q_data.last;
                unit_next   = pair ? lo_unit : {14'd0, q_data.cp_b};
            end
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg   <= unit_next;
        uvalid_reg <= uvalid_next;
        end_reg    <= end_next;
    end

    assign out_valid  = valid_reg;
    assign code_unit  = unit_reg;
    assign unit_valid = uvalid_reg;
    assign end_mark   = end_reg;

endmodule
`default_nettype wire

// ===== test/utf8_to_utf16_or_utf32_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_or_utf32_decoder_core_tb
// Self-checking bench for the UTF-8 decoder. A directed set of strings covers
// the lead byte classes, code point extremes, surrogate pairs, skipped bytes,
// the zero stop and strings cut inside a sequence. Random strings follow in
// both output modes. A scoreboard predicts every output word from the bytes
// accepted on the input and compares them in order, while the sender idles in
// bursts and the receiver stalls on patterns, once for a long stretch.
// ----------------------------------------------------------------------------
module utf8_to_utf16_or_utf32_decoder_core_tb
    import u8dec_pkg::*;
();

    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_BYTES    = 150;

    typedef struct packed {
        logic [20:0] unit;
        logic        has_unit;
        logic        last;
    } unit_word_t;

    typedef enum int {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_CYCLIC
    } rx_style_t;

    class utf_scoreboard;
        bit [7:0]    held [3];
        int unsigned held_cnt;
        bit          stopped;
        bit          mode;
        unit_word_t  unit_q [$];
        int          step_n;
        int          errors;

        function new();
            foreach (held[i])
                held[i] = 8'h00;
            held_cnt = 0;
            stopped  = 1'b0;
            mode     = MODE_UTF32;
            step_n   = 0;
            errors   = 0;
        endfunction

        function void set_mode(bit m);
            mode = m;
        endfunction

        function bit pending();
            return unit_q.size() != 0;
        endfunction

        function lead_cls_t classify(bit [7:0] b);
            if (b < 8'h80)
                return CLS_SINGLE;
            if (b < 8'hE0)
                return CLS_TWO;
            if (b < 8'hF0)
                return CLS_THREE;
            if (b < 8'hF8)
                return CLS_FOUR;
            return CLS_BAD;
        endfunction

        function bit [20:0] join_seq(bit [7:0] s [4], lead_cls_t cls);
            case (cls)
                CLS_TWO:   return 21'({s[0][4:0], s[1][5:0]});
                CLS_THREE: return 21'({s[0][3:0], s[1][5:0], s[2][5:0]});
                default:   return {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
            endcase
        endfunction

        // at most two words per byte; anything beyond is dropped
        function void push_unit(bit [20:0] u, bit v);
            if (step_n < 2)
            begin
                unit_q.insert(unit_q.size(), unit_word_t'({u, v, 1'b0}));
                step_n++;
            end
        endfunction

        function void push_code(bit [20:0] cp);
            bit [20:0] v;
            if (mode == MODE_UTF16 && cp > BMP_MAX)
            begin
                v = cp - SUPP_BASE;
                push_unit(HI_SURR + (v >> 10), 1'b1);
                push_unit(LO_SURR + (v & 21'h3FF), 1'b1);
            end
            else
                push_unit(cp, 1'b1);
        endfunction

        // string ended inside a sequence: drop the lead, decode the rest as leads
        function void decode_tail();
            bit [7:0]    t [4];
            bit [7:0]    w [4];
            int unsigned m;
            int unsigned i;
            int unsigned k;
            lead_cls_t   cls;
            foreach (t[j])
                t[j] = 8'h00;
            m = held_cnt - 1;
            for (int j = 0; j < m; j++)
                t[j] = held[j + 1];
            i = 0;
            while (i < m)
            begin
                if (t[i] == 8'h00)
                    break;
                cls = classify(t[i]);
                k   = int'(cls);
                if (cls == CLS_SINGLE)
                begin
                    push_code(21'(t[i]));
                    i++;
                end
                else if (cls != CLS_BAD && i + k < m)
                begin
                    for (int j = 0; j < 4; j++)
                        w[j] = (i + j < 4) ? t[i + j] : 8'h00;
                    push_code(join_seq(w, cls));
                    i += k + 1;
                end
                else
                    i++;
            end
        endfunction

        function void decode_byte(bit [7:0] b, bit last);
            bit [7:0]    seq [4];
            lead_cls_t   cls;
            int unsigned n;
            step_n = 0;
            if (!stopped)
            begin
                if (held_cnt == 0)
                begin
                    cls = classify(b);
                    if (b == 8'h00)
                        stopped = 1'b1;
                    else if (cls == CLS_SINGLE)
                        push_code(21'(b));
                    else if (cls != CLS_BAD)
                    begin
                        held[0]  = b;
                        held_cnt = 1;
                    end
                end
                else
                begin
                    cls = classify(held[0]);
                    n   = held_cnt;
                    for (int j = 0; j < 3; j++)
                        seq[j] = held[j];
                    seq[3] = 8'h00;
                    seq[n] = b;
                    if (cls != CLS_SINGLE && cls != CLS_BAD && n == int'(cls))
                    begin
                        push_code(join_seq(seq, cls));
                        held_cnt = 0;
                    end
                    else if (n < 3)
                    begin
                        held[n]  = b;
                        held_cnt = n + 1;
                    end
                    else
                        held_cnt = 0;
                end
            end
            if (last)
            begin
                if (!stopped && held_cnt > 1)
                    decode_tail();
                if (step_n == 0)
                    push_unit(21'h0, 1'b0);
                unit_q[unit_q.size() - 1].last = 1'b1;
                held_cnt = 0;
                stopped  = 1'b0;
            end
        endfunction

        function void check_unit(logic [20:0] u, logic v, logic e);
            unit_word_t want;
            if (unit_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: unit=%h valid=%b end=%b", u, v, e);
            end
            else
            begin
                want = unit_q.pop_front();
                if (want.unit !== u || want.has_unit !== v || want.last !== e)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("word mismatch: expected unit=%h valid=%b end=%b,",
                                 want.unit, want.has_unit, want.last,
                                 " got unit=%h valid=%b end=%b", u, v, e);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte     = 8'h00;
    logic        in_last     = 1'b0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [20:0] code_unit;
    logic        unit_valid;
    logic        end_mark;

    bit          hold_req = 1'b0;
    bit          rx_free  = 1'b0;
    bit [8:0]    stim_q [$];      // {last, byte}
    utf_scoreboard sb;

    utf8_to_utf16_or_utf32_decoder_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_unit   (code_unit),
        .unit_valid  (unit_valid),
        .end_mark    (end_mark)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void add_byte(bit [7:0] b, bit last);
        stim_q.insert(stim_q.size(), {last, b});
    endfunction

    // random strings of mostly well-formed characters, some noise and cut ends
    function automatic void add_random_text(int unsigned target);
        int unsigned nchars;
        int unsigned kind;
        int unsigned ncont;
        bit [7:0]    lead_b;
        bit [7:0]    cont_b;
        bit          cut;
        while (stim_q.size() < target)
        begin
            nchars = $urandom_range(1, 8);
            for (int c = 0; c < nchars; c++)
            begin
                kind  = $urandom_range(0, 99);
                ncont = 0;
                if (kind < 35)
                    lead_b = 8'($urandom_range(8'h01, 8'h7F));
                else if (kind < 55)
                begin
                    lead_b = 8'($urandom_range(8'h80, 8'hDF));
                    ncont  = 1;
                end
                else if (kind < 70)
                begin
                    lead_b = 8'($urandom_range(8'hE0, 8'hEF));
                    ncont  = 2;
                end
                else if (kind < 85)
                begin
                    lead_b = 8'($urandom_range(8'hF0, 8'hF7));
                    ncont  = 3;
                end
                else if (kind < 97)
                    lead_b = 8'($urandom_range(0, 1) ? $urandom_range(8'hF8, 8'hFF)
                                                     : $urandom_range(0, 255));
                else
                    lead_b = 8'h00;
                cut = (c == nchars - 1) && (ncont != 0) && ($urandom_range(0, 3) == 0);
                if (cut)
                    ncont = $urandom_range(0, ncont - 1);
                add_byte(lead_b, 1'b0);
                for (int j = 0; j < ncont; j++)
                begin
                    // a cut tail gets lead-like bytes so that it decodes again
                    if (cut)
                        cont_b = 8'($urandom_range(0, 8'hF7));
                    else if ($urandom_range(0, 7) == 0)
                        cont_b = 8'($urandom_range(0, 255));
                    else
                        cont_b = {2'b10, 6'($urandom_range(0, 63))};
                    add_byte(cont_b, 1'b0);
                end
            end
            stim_q[stim_q.size() - 1][8] = 1'b1;
        end
    endfunction

    task automatic write_mode(bit m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_mode(m);
    endtask

    // send queued words in bursts; hold each word until accepted
    task automatic drive_bytes();
        int       burst;
        int       gap;
        bit [8:0] w;
        burst = 0;
        while (stim_q.size() != 0)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            w = stim_q.pop_front();
            in_valid <= 1'b1;
            in_byte  <= w[7:0];
            in_last  <= w[8];
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            burst--;
        end
        in_valid <= 1'b0;
    endtask

    // drain all expected words, then let the pipeline go quiet
    task automatic settle();
        while (sb.pending())
            @(posedge clk);
        rx_free = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);
        rx_free = 1'b0;
    endtask

    // receiver stall pattern, with one long hold on request
    initial
    begin
        rx_style_t style;
        int        span;
        int        tick;
        style = RX_OPEN;
        span  = 0;
        tick  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (rx_free)
                out_stall <= 1'b0;
            else
            begin
                if (span == 0)
                begin
                    style = rx_style_t'($urandom_range(0, 3));
                    span  = $urandom_range(5, 60);
                end
                span--;
                tick++;
                case (style)
                    RX_OPEN:  out_stall <= 1'b0;
                    RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
                    RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
                    default:  out_stall <= (tick % 3 != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.decode_byte(in_byte, in_last);
        if (rst_n && out_valid && !out_stall)
            sb.check_unit(code_unit, unit_valid, end_mark);
    end

    // end the run when neither side moves a word for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        bit m;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // UTF-32: ASCII extremes, each lead class, largest value, skipped leads,
        // zero continuation byte
        write_mode(MODE_UTF32);
        add_byte(8'h01, 0); add_byte(8'h7F, 0);
        add_byte(8'hC2, 0); add_byte(8'hA9, 0);
        add_byte(8'hE2, 0); add_byte(8'h82, 0); add_byte(8'hAC, 0);
        add_byte(8'hF7, 0); add_byte(8'hBF, 0); add_byte(8'hBF, 0); add_byte(8'hBF, 0);
        add_byte(8'hF8, 0); add_byte(8'hFF, 0);
        add_byte(8'hC2, 0); add_byte(8'h00, 1);
        drive_bytes();
        settle();

        // UTF-16: surrogate pair at the top, cut four-byte sequence, zero stop,
        // string with nothing but a skipped byte
        write_mode(MODE_UTF16);
        add_byte(8'hF7, 0); add_byte(8'hBF, 0); add_byte(8'hBF, 0); add_byte(8'hBF, 0);
        add_byte(8'hF0, 0); add_byte(8'h41, 0); add_byte(8'h42, 1);
        add_byte(8'h00, 0); add_byte(8'h41, 1);
        add_byte(8'hFF, 1);
        drive_bytes();
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            m = (p < RANDOM_PHASES - 1) ? p[0] : 1'($urandom_range(0, 1));
            write_mode(m);
            add_random_text(PHASE_BYTES);
            if (p == 2)
                hold_req = 1'b1;
            drive_bytes();
            settle();
        end

        if (sb.errors == 0 && !sb.pending())
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== utf8_to_utf16_or_utf32_decoder_core.f =====
src/u8dec_pkg.sv
src/u8dec_front.sv
src/u8dec_queue.sv
src/u8dec_back.sv
src/utf8_to_utf16_or_utf32_decoder_core.sv
test/utf8_to_utf16_or_utf32_decoder_core_tb.sv
